### rtl/sle_pkg.sv
// Shared constants and codes for the sorted list engine.
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned MAX_RESULTS  = 16;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned RCNT_W   = 5;
  localparam int unsigned MCNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

### rtl/sle_store.sv
// Entry store: one write port, one enabled read port with registered data.
module sle_store #(
  parameter int unsigned DEPTH = sle_pkg::CAPACITY_DEF,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [IW-1:0]               waddr_i,
  input  logic [sle_pkg::DATA_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [IW-1:0]               raddr_i,
  output logic [sle_pkg::DATA_W-1:0]  rdata_o
);

  logic [sle_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [sle_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_list_engine.sv
// Sorted list engine: ascending store of signed words, insert / find / remove.
// Insert walks from the top, shifting entries up; find and remove walk from the bottom;
// then the result words follow, one per cycle while the output is not stalled.
// A new request is taken only in idle, after every result word of the last one is sent;
// the walks are paced by the single store read port and shared comparator.
// Reset: entry count and handshake state clear at once; stored entries are not cleared.
module sorted_list_engine #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sle_pkg::REQ_W-1:0]     req_type_i,
  input  logic [sle_pkg::DATA_W-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sle_pkg::STATUS_W-1:0]  status_o,
  output logic [sle_pkg::POS_W-1:0]     position_o,
  output logic [sle_pkg::RCNT_W-1:0]    removed_count_o,
  output logic                          last_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = sle_pkg::MCNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_REM  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          dv_q, dv_d;
  logic                          out_valid_q, out_valid_d;

  logic signed [sle_pkg::DATA_W-1:0] key_q, key_d;
  logic [CW-1:0]                 rp_q, rp_d;
  logic [CW-1:0]                 left_q, left_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 wp_q, wp_d;
  logic [CW-1:0]                 f_q, f_d;
  logic [MW-1:0]                 mcnt_q, mcnt_d;
  logic [MW-1:0]                 tot_q, tot_d;
  logic [MW-1:0]                 e_q, e_d;
  logic [sle_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic [sle_pkg::RCNT_W-1:0]    rc_q, rc_d;

  logic [sle_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [sle_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [sle_pkg::RCNT_W-1:0]    rcnt_q, rcnt_d;
  logic                          last_q, last_d;

  logic                          we;
  logic [IW-1:0]                 waddr;
  logic [sle_pkg::DATA_W-1:0]    wdata;
  logic                          rd_en;
  logic [sle_pkg::DATA_W-1:0]    rdata_raw;
  logic signed [sle_pkg::DATA_W-1:0] rdata;

  logic                          lt, eq, last_idx, emit_last;
  logic [MW-1:0]                 m_next;
  logic [CW-1:0]                 wp_next, removed;

  sle_store #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rp_q[IW-1:0]),
    .rdata_o (rdata_raw)
  );

  // shared comparator: stored entry against the request key
  assign rdata    = $signed(rdata_raw);
  assign lt       = rdata < key_q;
  assign eq       = rdata == key_q;
  assign last_idx = idx_q == CW'(cnt_q - CW'(1));
  assign m_next   = mcnt_q + MW'(eq);
  assign wp_next  = eq ? wp_q : CW'(wp_q + CW'(1));
  assign removed  = CW'(cnt_q - wp_next);
  assign emit_last = e_q == MW'(tot_q - MW'(1));

  assign rd_en = ((state_q == S_INS) || (state_q == S_FIND) || (state_q == S_REM)) &&
                 (left_q != '0);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    key_d        = key_q;
    wp_d         = wp_q;
    f_d          = f_q;
    mcnt_d       = mcnt_q;
    tot_d        = tot_q;
    e_d          = e_q;
    res_status_d = res_status_q;
    rc_d         = rc_q;
    rp_d         = rp_q;
    left_d       = left_q;
    idx_d        = idx_q;
    dv_d         = rd_en;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    pos_d        = pos_q;
    rcnt_d       = rcnt_q;
    last_d       = last_q;
    we           = 1'b0;
    waddr        = '0;
    wdata        = rdata_raw;

    if (rd_en) begin
      left_d = CW'(left_q - CW'(1));
      idx_d  = rp_q;
      rp_d   = (state_q == S_INS) ? CW'(rp_q - CW'(1)) : CW'(rp_q + CW'(1));
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d  = $signed(value_i);
          e_d    = '0;
          rc_d   = '0;
          f_d    = '0;
          tot_d  = MW'(1);
          mcnt_d = '0;
          wp_d   = '0;
          case (req_type_i)
            sle_pkg::REQ_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_status_d = sle_pkg::ST_FULL;
                state_d      = S_EMIT;
              end else if (cnt_q == '0) begin
                state_d = S_TAIL;
              end else begin
                rp_d    = CW'(cnt_q - CW'(1));
                left_d  = cnt_q;
                state_d = S_INS;
              end
            end
            sle_pkg::REQ_FIND, sle_pkg::REQ_REMOVE: begin
              if (cnt_q == '0) begin
                res_status_d = sle_pkg::ST_EMPTY;
                state_d      = S_EMIT;
              end else begin
                rp_d    = '0;
                left_d  = cnt_q;
                state_d = (req_type_i == sle_pkg::REQ_FIND) ? S_FIND : S_REM;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        // shift entries not less than the key up by one, top down
        if (dv_q) begin
          we    = 1'b1;
          waddr = IW'(CW'(idx_q + CW'(1)));
          if (!lt) begin
            wdata = rdata_raw;
            if (idx_q == '0) begin
              state_d = S_TAIL;
            end
          end else begin
            wdata        = key_q;
            f_d          = CW'(idx_q + CW'(1));
            cnt_d        = CW'(cnt_q + CW'(1));
            res_status_d = sle_pkg::ST_OK;
            state_d      = S_EMIT;
          end
        end
      end
      S_TAIL: begin
        we           = 1'b1;
        waddr        = '0;
        wdata        = key_q;
        f_d          = '0;
        cnt_d        = CW'(cnt_q + CW'(1));
        res_status_d = sle_pkg::ST_OK;
        state_d      = S_EMIT;
      end
      S_FIND: begin
        // matches are contiguous: record first position and run length
        if (dv_q) begin
          mcnt_d = m_next;
          if (eq && (mcnt_q == '0)) begin
            f_d = idx_q;
          end
          if ((!lt && !eq) || last_idx || (m_next == MW'(sle_pkg::MAX_RESULTS))) begin
            if (m_next == '0) begin
              res_status_d = sle_pkg::ST_NOT_FOUND;
              tot_d        = MW'(1);
            end else begin
              res_status_d = sle_pkg::ST_OK;
              tot_d        = m_next;
            end
            state_d = S_EMIT;
          end
        end
      end
      S_REM: begin
        // compact survivors downward; write pointer never passes the read pointer
        if (dv_q) begin
          if (!eq) begin
            we    = 1'b1;
            waddr = wp_q[IW-1:0];
            wdata = rdata_raw;
          end
          wp_d = wp_next;
          if (last_idx) begin
            cnt_d = wp_next;
            if (removed == '0) begin
              res_status_d = sle_pkg::ST_NOT_FOUND;
            end else begin
              res_status_d = sle_pkg::ST_OK;
              rc_d         = sle_pkg::RCNT_W'(removed);
            end
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          pos_d       = sle_pkg::POS_W'(CW'(f_q + CW'(e_q)));
          rcnt_d      = rc_q;
          last_d      = emit_last;
          e_d         = MW'(e_q + MW'(1));
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    rp_q         <= rp_d;
    left_q       <= left_d;
    idx_q        <= idx_d;
    wp_q         <= wp_d;
    f_q          <= f_d;
    mcnt_q       <= mcnt_d;
    tot_q        <= tot_d;
    e_q          <= e_d;
    res_status_q <= res_status_d;
    rc_q         <= rc_d;
    status_q     <= status_d;
    pos_q        <= pos_d;
    rcnt_q       <= rcnt_d;
    last_q       <= last_d;
  end

  assign in_ready_o      = state_q == S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign position_o      = pos_q;
  assign removed_count_o = rcnt_q;
  assign last_o          = last_q;

endmodule

### rtl/sle_checker.sv
// Port-level checks for the sorted list engine, bound to the top level.
module sle_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [sle_pkg::REQ_W-1:0]     req_type_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [sle_pkg::STATUS_W-1:0]  status_o,
  input logic [sle_pkg::POS_W-1:0]     position_o,
  input logic [sle_pkg::RCNT_W-1:0]    removed_count_o,
  input logic                          last_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable({status_o, position_o, removed_count_o, last_o}))
    else $error("result word changed while stalled");

  // a real request keeps the block busy the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
      (req_type_i == sle_pkg::REQ_INSERT || req_type_i == sle_pkg::REQ_FIND ||
       req_type_i == sle_pkg::REQ_REMOVE) |=> !in_ready_o)
    else $error("ready right after accepting a request");

  // error results are single words with no position
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sle_pkg::ST_OK |-> last_o && position_o == '0)
    else $error("error result not a single zero-position word");

  // a removal count only comes on a final ok word with no position
  a_rcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_count_o != '0 |->
      status_o == sle_pkg::ST_OK && last_o && position_o == '0)
    else $error("removal count on a wrong word");

  // empty and full words never carry a removal count
  a_no_rcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sle_pkg::ST_EMPTY || status_o == sle_pkg::ST_FULL) |->
      removed_count_o == '0)
    else $error("removal count on empty or full word");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);

### bench/tb_top.sv
// Self-checking bench for the sorted list engine: directed and random requests against a shadow list.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned STORE_DEPTH = sle_pkg::CAPACITY_DEF;
  localparam logic [sle_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [6:0] STALL_PAT = 7'b1011001;
  localparam int RANDOM_REQS = 136;

  typedef struct {
    logic [sle_pkg::REQ_W-1:0]  kind;
    logic [sle_pkg::DATA_W-1:0] value;
    logic                       hold;   // marker: sender waits until all replies are in
  } list_req_t;

  typedef struct {
    sle_pkg::status_e           status;
    logic [sle_pkg::POS_W-1:0]  pos;
    logic [sle_pkg::RCNT_W-1:0] rcnt;
    logic                       last;
  } list_reply_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [sle_pkg::REQ_W-1:0]    req_type = '0;
  logic [sle_pkg::DATA_W-1:0]   value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b1;
  logic [sle_pkg::STATUS_W-1:0] status;
  logic [sle_pkg::POS_W-1:0]    position;
  logic [sle_pkg::RCNT_W-1:0]   removed_count;
  logic                         last;

  list_req_t         request_q[$];
  list_reply_t       reply_q[$];
  logic signed [31:0] shadow_list[$];

  int        fail_cnt = 0;
  bit        req_taken = 1'b0;
  bit        drain_wait = 1'b0;
  int        burst_left = 6;
  int        gap_left = 0;
  int        stall_left = 0;
  int        pat_idx = 0;
  int        cyc_cnt = 0;
  list_req_t nxt_req;
  list_reply_t got;

  sorted_list_engine #(.CAPACITY(STORE_DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .position_o     (position),
    .removed_count_o(removed_count),
    .last_o         (last)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_reply(sle_pkg::status_e st, int pos, int rcnt, logic fin);
    list_reply_t r;
    r.status = st;
    r.pos    = sle_pkg::POS_W'(pos);
    r.rcnt   = sle_pkg::RCNT_W'(rcnt);
    r.last   = fin;
    reply_q.push_back(r);
  endfunction

  // Updates the shadow list for one accepted request and queues the replies it must produce.
  task automatic compute_list_replies(input logic [sle_pkg::REQ_W-1:0] kind,
                                      input logic [sle_pkg::DATA_W-1:0] raw);
    logic signed [31:0] key;
    logic signed [31:0] kept[$];
    int pos;
    int hits;
    int emitted;
    key = raw;
    pos = 0;
    hits = 0;
    emitted = 0;
    if (kind == sle_pkg::REQ_INSERT) begin
      if (shadow_list.size() >= STORE_DEPTH) begin
        add_reply(sle_pkg::ST_FULL, 0, 0, 1'b1);
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] < key) pos++;
        shadow_list.insert(pos, key);
        add_reply(sle_pkg::ST_OK, pos, 0, 1'b1);
      end
    end else if (shadow_list.size() == 0) begin
      add_reply(sle_pkg::ST_EMPTY, 0, 0, 1'b1);
    end else if (kind == sle_pkg::REQ_FIND) begin
      foreach (shadow_list[i]) if (shadow_list[i] == key) hits++;
      if (hits > sle_pkg::MAX_RESULTS) hits = sle_pkg::MAX_RESULTS;
      if (hits == 0) add_reply(sle_pkg::ST_NOT_FOUND, 0, 0, 1'b1);
      foreach (shadow_list[i]) begin
        if (shadow_list[i] == key && emitted < hits) begin
          emitted++;
          add_reply(sle_pkg::ST_OK, i, 0, emitted == hits);
        end
      end
    end else begin
      foreach (shadow_list[i]) begin
        if (shadow_list[i] == key) hits++;
        else kept.push_back(shadow_list[i]);
      end
      shadow_list = kept;
      if (hits == 0) add_reply(sle_pkg::ST_NOT_FOUND, 0, 0, 1'b1);
      else add_reply(sle_pkg::ST_OK, 0, hits, 1'b1);
    end
  endtask

  // Sender: bursts of words separated by random gaps; hold markers pause until drained.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // word still waiting for ready
    end else begin
      req_taken = 1'b0;
      if (drain_wait) begin
        if (reply_q.size() == 0) drain_wait = 1'b0;
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        nxt_req = request_q.pop_front();
        if (nxt_req.hold) begin
          drain_wait = 1'b1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          req_type <= nxt_req.kind;
          value    <= nxt_req.value;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: cycles through always-ready, random, long-stall and fixed-pattern phases.
  always @(negedge clk_i) begin
    cyc_cnt++;
    case (cyc_cnt[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 20);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
      default: begin
        out_ready <= STALL_PAT[pat_idx];
        pat_idx = (pat_idx == 6) ? 0 : pat_idx + 1;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        req_taken = 1'b1;
        if (req_type != REQ_UNUSED) compute_list_replies(req_type, value);
      end
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected reply status=%0d pos=%0d rcnt=%0d last=%0d",
                     $realtime, status, position, removed_count, last);
        end else begin
          got = reply_q.pop_front();
          if (status !== got.status || position !== got.pos ||
              removed_count !== got.rcnt || last !== got.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: exp status=%0d pos=%0d rcnt=%0d last=%0d, got %0d %0d %0d %0d",
                       $realtime, got.status, got.pos, got.rcnt, got.last,
                       status, position, removed_count, last);
          end
        end
      end
    end
  end

  initial begin
    logic [sle_pkg::DATA_W-1:0] pool[8];
    list_req_t r;
    int issued;
    int ins_w;
    int roll;

    r.hold = 1'b0;
    // directed: empty store, fill with one value, full store, bulk find and remove
    r.value = 32'd5;
    r.kind = sle_pkg::REQ_FIND;   request_q.push_back(r);
    r.kind = sle_pkg::REQ_REMOVE; request_q.push_back(r);
    r.kind = sle_pkg::REQ_INSERT;
    repeat (STORE_DEPTH + 1) request_q.push_back(r);
    r.kind = sle_pkg::REQ_FIND;   request_q.push_back(r);
    r.kind = sle_pkg::REQ_REMOVE; request_q.push_back(r);
    r.kind = REQ_UNUSED;          request_q.push_back(r);
    r.kind = sle_pkg::REQ_INSERT; r.value = 32'h7fff_ffff; request_q.push_back(r);
    r.kind = sle_pkg::REQ_INSERT; r.value = 32'h8000_0000; request_q.push_back(r);
    r.kind = sle_pkg::REQ_FIND;   r.value = 32'h7fff_ffff; request_q.push_back(r);
    r.kind = sle_pkg::REQ_FIND;   r.value = 32'h0;         request_q.push_back(r);
    r.hold = 1'b1;
    request_q.push_back(r);
    r.hold = 1'b0;

    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;

    issued = 0;
    while (issued < RANDOM_REQS) begin
      // alternate between phases that fill the store and phases that drain it
      ins_w = ((issued / 40) % 2) ? 30 : 60;
      roll = $urandom_range(0, 99);
      if (roll < 4) r.kind = REQ_UNUSED;
      else if (roll < ins_w) r.kind = sle_pkg::REQ_INSERT;
      else if (roll < ins_w + (100 - ins_w) / 2) r.kind = sle_pkg::REQ_FIND;
      else r.kind = sle_pkg::REQ_REMOVE;
      r.value = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 7)] : $urandom;
      request_q.push_back(r);
      if (r.kind != REQ_UNUSED) begin
        issued++;
        if (issued % 50 == 0) begin
          r.hold = 1'b1;
          request_q.push_back(r);
          r.hold = 1'b0;
        end
      end
    end

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || in_valid || drain_wait || reply_q.size() != 0)
      @(posedge clk_i);
    repeat (2 * STORE_DEPTH + 8) @(posedge clk_i);

    if (fail_cnt == 0 && reply_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/sle_pkg.sv
rtl/sle_store.sv
rtl/sorted_list_engine.sv
rtl/sle_checker.sv
bench/tb_top.sv
